FILE: rtl/core/cpf_pkg.sv
// Shared constants for the chunked packet framer.
`default_nettype none

package cpf_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 16;
    // Dividend of the packet-count division: length + payload - 1, one bit wider.
    localparam int DVD_W  = LEN_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_BYTE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [BYTE_W-1:0] HEAD_BYTE_RST   = 8'd170;
    localparam logic [BYTE_W-1:0] TYPE_BYTE_RST   = 8'd1;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RST = 8'd10;

endpackage

`default_nettype wire

FILE: rtl/core/cpf_div.sv
// Iterative restoring divider: one quotient bit per cycle, computes the packet count.
`default_nettype none

module cpf_div
    import cpf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DVD_W-1:0]  dividend,
    input  wire logic [BYTE_W-1:0] divisor,
    output logic                   done,
    output logic [LEN_W-1:0]       quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [BYTE_W-1:0] rem_reg;
    logic [BYTE_W-1:0] dvs_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [BYTE_W:0]   rem_sh;
    logic              ge;
    logic [BYTE_W:0]   rem_next;

    // subtract/compare step
    always_comb
    begin
        rem_sh   = {rem_reg, q_reg[DVD_W-1]};
        ge       = (rem_sh >= {1'b0, dvs_reg});
        rem_next = ge ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                q_reg    <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next[BYTE_W-1:0];
                q_reg   <= {q_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg[LEN_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/chunked_packet_framer.sv
// Chunked packet framer top level: byte sequencer, checksum and output register.
// First result is registered in the emit state after an accepted byte, then one result per
// cycle while the output is not stalled; the first byte of a message first waits for the
// bit-serial packet-count divider. A byte causes 1, 2, 10 or 11 results and input reopens
// once the last one is registered; the output register lets that input in while the last
// result waits. Reset (async, active low) restores config defaults, closes any message and
// empties the output register.
`default_nettype none

module chunked_packet_framer
    import cpf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [23:0]          s_axis_tdata,  // [7:0] msg_byte, [23:8] msg_length
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]                m_axis_tuser,  // [0] packet_end, [1] message_end
    output logic                      m_axis_tlast,  // run_last
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_t;
    typedef enum logic [3:0] {
        STEP_HEAD, STEP_TYPE, STEP_SEQ_HI, STEP_SEQ_LO, STEP_TOT_HI, STEP_TOT_LO,
        STEP_LEN_HI, STEP_LEN_LO, STEP_CHUNK, STEP_PAYLOAD, STEP_CSUM
    } step_t;

    logic [BYTE_W-1:0] head_byte_reg;
    logic [BYTE_W-1:0] type_byte_reg;
    logic [BYTE_W-1:0] max_payload_reg;

    state_t            state_reg;
    step_t             step_reg;
    logic              in_message_reg;
    logic [LEN_W-1:0]  seq_number_reg;
    logic [LEN_W-1:0]  packet_total_reg;
    logic [LEN_W-1:0]  length_held_reg;
    logic [LEN_W-1:0]  bytes_left_reg;
    logic [BYTE_W-1:0] chunk_left_reg;
    logic [BYTE_W-1:0] running_sum_reg;
    logic [BYTE_W-1:0] byte_reg;

    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic              m_tlast_reg;

    logic [BYTE_W-1:0] msg_byte;
    logic [LEN_W-1:0]  msg_length;
    logic              in_accept;
    logic              div_start;
    logic              div_done;
    logic [LEN_W-1:0]  div_quot;
    logic [DVD_W-1:0]  div_dividend;
    logic [BYTE_W-1:0] eff_payload;
    logic [BYTE_W-1:0] chunk_size;
    logic              slot_free;
    logic              emit_fire;
    logic              chunk_ends;
    logic              pend;
    logic              mend;
    logic              run_last;
    logic [BYTE_W-1:0] emit_byte;

    assign msg_byte   = s_axis_tdata[7:0];
    assign msg_length = s_axis_tdata[23:8];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign div_start     = in_accept && !in_message_reg && (msg_length != '0);

    assign eff_payload  = (max_payload_reg == '0) ? BYTE_W'(1) : max_payload_reg;
    assign div_dividend = {1'b0, msg_length} + {{(DVD_W-BYTE_W){1'b0}}, eff_payload}
                          - DVD_W'(1);

    cpf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (eff_payload),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        chunk_size = (bytes_left_reg < {{(LEN_W-BYTE_W){1'b0}}, eff_payload})
                     ? bytes_left_reg[BYTE_W-1:0] : eff_payload;
        slot_free  = !m_tvalid_reg || m_axis_tready;
        emit_fire  = (state_reg == ST_EMIT) && slot_free;
        chunk_ends = (chunk_left_reg == BYTE_W'(1));
        pend       = (step_reg == STEP_CSUM);
        mend       = pend && (bytes_left_reg == '0);
        run_last   = pend || ((step_reg == STEP_PAYLOAD) && !chunk_ends);
        case (step_reg)
            STEP_HEAD:    emit_byte = head_byte_reg;
            STEP_TYPE:    emit_byte = type_byte_reg;
            STEP_SEQ_HI:  emit_byte = seq_number_reg[15:8];
            STEP_SEQ_LO:  emit_byte = seq_number_reg[7:0];
            STEP_TOT_HI:  emit_byte = packet_total_reg[15:8];
            STEP_TOT_LO:  emit_byte = packet_total_reg[7:0];
            STEP_LEN_HI:  emit_byte = length_held_reg[15:8];
            STEP_LEN_LO:  emit_byte = length_held_reg[7:0];
            STEP_CHUNK:   emit_byte = chunk_size;
            STEP_PAYLOAD: emit_byte = byte_reg;
            STEP_CSUM:    emit_byte = running_sum_reg;
            default:      emit_byte = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_byte_reg   <= HEAD_BYTE_RST;
            type_byte_reg   <= TYPE_BYTE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEAD_BYTE:   head_byte_reg   <= cfg_data;
                CFG_TYPE_BYTE:   type_byte_reg   <= cfg_data;
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= STEP_HEAD;
            in_message_reg   <= 1'b0;
            seq_number_reg   <= '0;
            packet_total_reg <= '0;
            length_held_reg  <= '0;
            bytes_left_reg   <= '0;
            chunk_left_reg   <= '0;
            running_sum_reg  <= '0;
            byte_reg         <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tuser_reg      <= '0;
            m_tlast_reg      <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && !emit_fire)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        byte_reg <= msg_byte;
                        if (!in_message_reg)
                        begin
                            // zero length drops the byte and stays idle
                            if (msg_length != '0)
                            begin
                                length_held_reg <= msg_length;
                                bytes_left_reg  <= msg_length;
                                seq_number_reg  <= '0;
                                chunk_left_reg  <= '0;
                                in_message_reg  <= 1'b1;
                                state_reg       <= ST_DIV;
                            end
                        end
                        else
                        begin
                            step_reg  <= (chunk_left_reg == '0) ? STEP_HEAD : STEP_PAYLOAD;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        packet_total_reg <= div_quot;
                        step_reg         <= STEP_HEAD;
                        state_reg        <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= emit_byte;
                        m_tuser_reg  <= {mend, pend};
                        m_tlast_reg  <= run_last;
                        step_reg     <= step_t'(step_reg + 4'd1);
                        case (step_reg)
                            STEP_HEAD:
                            begin
                                running_sum_reg <= '0;
                            end
                            STEP_PAYLOAD:
                            begin
                                running_sum_reg <= running_sum_reg + emit_byte;
                                chunk_left_reg  <= chunk_left_reg - 1'b1;
                                bytes_left_reg  <= bytes_left_reg - 1'b1;
                                if (!chunk_ends)
                                begin
                                    state_reg <= ST_IDLE;
                                end
                            end
                            STEP_CSUM:
                            begin
                                state_reg <= ST_IDLE;
                                if (bytes_left_reg == '0)
                                begin
                                    in_message_reg <= 1'b0;
                                end
                                else
                                begin
                                    seq_number_reg <= seq_number_reg + 1'b1;
                                end
                            end
                            default:
                            begin
                                running_sum_reg <= running_sum_reg + emit_byte;
                                if (step_reg == STEP_CHUNK)
                                begin
                                    chunk_left_reg <= chunk_size;
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;

    // a message end is always a packet end and closes the run
    a_mend_is_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tuser[0] && m_axis_tlast))
        else $error("message_end without packet_end or tlast");

    // divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside of count phase");

    // no partial chunk outside an open message
    a_idle_no_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        !in_message_reg |-> (chunk_left_reg == '0))
        else $error("chunk count left over with no open message");

    // a payload byte is emitted only with a nonzero chunk count
    a_payload_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && step_reg == STEP_PAYLOAD) |-> (chunk_left_reg != '0))
        else $error("payload step with empty chunk");

endmodule

`default_nettype wire

FILE: verif/tb_chunked_packet_framer.sv
// Testbench for the chunked packet framer: stream driver, scoreboard and framing predictor.
`default_nettype none

class framer_scoreboard;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       msg_end;
        logic       last;
    } frame_byte_t;

    logic [7:0]  head_val;
    logic [7:0]  type_val;
    logic [7:0]  payload_max;

    bit          open_msg;
    logic [15:0] seq_num;
    logic [15:0] pkt_total;
    logic [15:0] len_held;
    logic [15:0] bytes_left;
    logic [7:0]  chunk_left;
    logic [7:0]  frame_sum;

    frame_byte_t expected_bytes[$];
    frame_byte_t run_bytes[$];

    int errors;
    int inputs_seen;
    int results_seen;
    int packets_seen;
    int messages_seen;

    function new();
        head_val    = cpf_pkg::HEAD_BYTE_RST;
        type_val    = cpf_pkg::TYPE_BYTE_RST;
        payload_max = cpf_pkg::MAX_PAYLOAD_RST;
        open_msg    = 1'b0;
        seq_num     = '0;
        pkt_total   = '0;
        len_held    = '0;
        bytes_left  = '0;
        chunk_left  = '0;
        frame_sum   = '0;
    endfunction

    function void write_reg(logic [cpf_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        case (idx)
            cpf_pkg::CFG_HEAD_BYTE:   head_val = val;
            cpf_pkg::CFG_TYPE_BYTE:   type_val = val;
            cpf_pkg::CFG_MAX_PAYLOAD: payload_max = val;
            default: ;
        endcase
    endfunction

    function void add_byte(logic [7:0] b, bit summed, bit pe, bit me);
        frame_byte_t fb;
        if (summed)
            frame_sum = frame_sum + b;
        fb.data    = b;
        fb.pkt_end = pe;
        fb.msg_end = me;
        fb.last    = 1'b0;
        run_bytes.push_back(fb);
    endfunction

    // Expand one accepted message byte into the packet bytes it releases.
    function void note_input(logic [7:0] b, logic [15:0] length);
        logic [7:0]  eff;
        logic [16:0] dvd;
        logic [7:0]  clen;
        frame_byte_t fb;
        eff = (payload_max == 8'd0) ? 8'd1 : payload_max;
        inputs_seen++;
        if (!open_msg) begin
            if (length == 16'd0)
                return;
            len_held   = length;
            bytes_left = length;
            dvd        = {1'b0, length} + {9'b0, eff} - 17'd1;
            pkt_total  = 16'(dvd / {9'b0, eff});
            seq_num    = '0;
            chunk_left = '0;
            open_msg   = 1'b1;
        end
        run_bytes.delete();
        if (chunk_left == 8'd0) begin
            clen       = (bytes_left < {8'b0, eff}) ? bytes_left[7:0] : eff;
            chunk_left = clen;
            frame_sum  = '0;
            add_byte(head_val, 1'b0, 1'b0, 1'b0);
            add_byte(type_val, 1'b1, 1'b0, 1'b0);
            add_byte(seq_num[15:8], 1'b1, 1'b0, 1'b0);
            add_byte(seq_num[7:0], 1'b1, 1'b0, 1'b0);
            add_byte(pkt_total[15:8], 1'b1, 1'b0, 1'b0);
            add_byte(pkt_total[7:0], 1'b1, 1'b0, 1'b0);
            add_byte(len_held[15:8], 1'b1, 1'b0, 1'b0);
            add_byte(len_held[7:0], 1'b1, 1'b0, 1'b0);
            add_byte(clen, 1'b1, 1'b0, 1'b0);
        end
        add_byte(b, 1'b1, 1'b0, 1'b0);
        chunk_left = chunk_left - 8'd1;
        bytes_left = bytes_left - 16'd1;
        if (chunk_left == 8'd0) begin
            add_byte(frame_sum, 1'b0, 1'b1, bytes_left == 16'd0);
            packets_seen++;
            if (bytes_left == 16'd0) begin
                open_msg = 1'b0;
                messages_seen++;
            end
            else
            begin
                seq_num = seq_num + 16'd1;
            end
        end
        foreach (run_bytes[i])
        begin
            fb      = run_bytes[i];
            fb.last = (i == run_bytes.size() - 1);
            expected_bytes.push_back(fb);
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 50)
            $display("ERROR: %s", msg);
    endtask

    task check_result(logic [7:0] data, logic [1:0] user, logic last);
        frame_byte_t want;
        results_seen++;
        if (expected_bytes.size() == 0) begin
            report($sformatf("output byte 0x%02h with nothing outstanding", data));
            return;
        end
        want = expected_bytes.pop_front();
        if (data !== want.data)
            report($sformatf("out byte %0d: got 0x%02h, want 0x%02h",
                             results_seen, data, want.data));
        if (user[0] !== want.pkt_end)
            report($sformatf("out byte %0d: packet_end %b, want %b",
                             results_seen, user[0], want.pkt_end));
        if (user[1] !== want.msg_end)
            report($sformatf("out byte %0d: message_end %b, want %b",
                             results_seen, user[1], want.msg_end));
        if (last !== want.last)
            report($sformatf("out byte %0d: tlast %b, want %b",
                             results_seen, last, want.last));
    endtask

    function int pending();
        return expected_bytes.size();
    endfunction

endclass

module tb_chunked_packet_framer;

    import cpf_pkg::*;

    localparam int SETTLE_CYCLES = 40;   // divider plus a full packet, with margin
    localparam int QUIET_LIMIT   = 4000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;   // [7:0] msg_byte, [23:8] msg_length
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // [7:0] out_byte
    logic [1:0]           m_axis_tuser;         // [0] packet_end, [1] message_end
    logic                 m_axis_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    framer_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    chunked_packet_framer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Transaction monitor: config writes, accepted inputs, accepted outputs.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata[7:0], s_axis_tdata[23:8]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("ERROR: no transaction for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [15:0] length);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {length, b};
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Later bytes carry random lengths; the block must ignore them.
    task automatic send_message(input logic [15:0] length);
        for (int i = 0; i < length; i++)
        begin
            send_byte(8'($urandom_range(255)), (i == 0) ? length : 16'($urandom));
            items_sent++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] head, input logic [7:0] kind,
                            input logic [7:0] payload);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HEAD_BYTE;
        cfg_data  <= head;
        @(posedge clk);
        cfg_index <= CFG_TYPE_BYTE;
        cfg_data  <= kind;
        @(posedge clk);
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data  <= payload;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [7:0] payload,
                             input int target);
        int start;
        int eff;
        int max_len;
        drain();
        set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), payload);
        idle_pct  = idle;
        stall_pct = stall;
        start     = items_sent;
        eff       = (payload == 8'd0) ? 1 : int'(payload);
        max_len   = (4 * eff + 3 > 40) ? 40 : 4 * eff + 3;
        while (items_sent - start < target)
        begin
            // zero-length first bytes are noise the block drops
            if ($urandom_range(9) == 0)
                send_byte(8'($urandom_range(255)), 16'd0);
            if ($urandom_range(7) == 0)
                drain();
            send_message(16'($urandom_range(1, max_len)));
        end
    endtask

    initial
    begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset config, dropped zero-length byte, single-byte and three-byte messages
        send_byte(8'h3C, 16'd0);
        send_byte(8'hFF, 16'd1);
        send_byte(8'h00, 16'd3);
        send_byte(8'h80, 16'hFFFF);
        send_byte(8'h7F, 16'h0000);
        // payload of zero behaves as one
        drain();
        set_regs(8'h00, 8'hFF, 8'd0);
        send_byte(8'h55, 16'd2);
        send_byte(8'hAA, 16'h1234);
        // payload raised mid-message; packet count stays as latched
        drain();
        set_regs(8'hFF, 8'h00, 8'd2);
        send_byte(8'h01, 16'd5);
        send_byte(8'h02, 16'd0);
        drain();
        set_regs(8'h5A, 8'hA5, 8'd255);
        send_byte(8'h03, 16'd7);
        send_byte(8'hFE, 16'hFFFF);
        send_byte(8'h04, 16'd1);

        run_phase(0, 0, 8'($urandom_range(2, 16)), 60);
        run_phase(74, 0, 8'd1, 60);
        run_phase(0, 74, 8'd255, 60);
        run_phase(21, 21, 8'd0, 60);

        // longest length with one-byte packets: header counts near full scale
        drain();
        set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'd1);
        idle_pct  = 0;
        stall_pct = 0;
        send_byte(8'($urandom_range(255)), 16'hFFFF);
        repeat (11) send_byte(8'($urandom_range(255)), 16'($urandom));
        drain();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d output bytes never arrived", sb.pending()));
        $display("Covered %0d input and %0d output transactions: %0d packets, %0d messages.",
                 sb.inputs_seen, sb.results_seen, sb.packets_seen, sb.messages_seen);
        $display("Payload 0/1/2/255 and random, idle phases none, 74%% in, 74%% out, 21%% both.");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

FILE: chunked_packet_framer.f
rtl/core/cpf_pkg.sv
rtl/core/cpf_div.sv
rtl/core/chunked_packet_framer.sv
verif/tb_chunked_packet_framer.sv
